>>> src/brr_pkg.sv
// ----------------------------------------------------------------------------
// brr_pkg
// Shared types, constants and filter coefficient tables for the BRR decoder.
// ----------------------------------------------------------------------------
package brr_pkg;

  localparam int BLOCK_BYTES = 9;
  localparam int POS_W       = $clog2(BLOCK_BYTES);
  localparam int Q_DEPTH     = 2;
  localparam int Q_PTR_W     = $clog2(Q_DEPTH);
  localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

  localparam logic [POS_W-1:0] POS_HEADER = '0;
  localparam logic [POS_W-1:0] POS_LAST   = POS_W'(BLOCK_BYTES - 1);

  // One data byte together with the header that governs it
  typedef struct packed {
    logic [7:0] data;
    logic [1:0] filter;
    logic [3:0] shift_range;
    logic       end_flag;
    logic       loop_flag;
  } brr_entry_t;

  // Prediction coefficients in 1/64 units
  function automatic logic signed [7:0] coef_a(input logic [1:0] filter);
    logic signed [7:0] c;
    unique case (filter)
      2'd0:    c = 8'sd0;
      2'd1:    c = 8'sd60;
      2'd2:    c = 8'sd122;
      default: c = 8'sd115;
    endcase
    return c;
  endfunction

  function automatic logic signed [7:0] coef_b(input logic [1:0] filter);
    logic signed [7:0] c;
    unique case (filter)
      2'd0:    c = 8'sd0;
      2'd1:    c = 8'sd0;
      2'd2:    c = -8'sd60;
      default: c = -8'sd52;
    endcase
    return c;
  endfunction

endpackage

>>> src/brr_front.sv
// ----------------------------------------------------------------------------
// brr_front
// Accepts stream bytes, tracks the block position, latches headers and
// pushes data bytes with their header fields into the queue.
// ----------------------------------------------------------------------------
module brr_front import brr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_stream_byte,
  input  logic       q_full,
  output logic       push,
  output brr_entry_t push_entry
);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [1:0]       filter_r, filter_nxt;
  logic [3:0]       range_r, range_nxt;
  logic             end_r, end_nxt;
  logic             loop_r, loop_nxt;
  logic             accept;
  logic             is_header;

  assign in_stall  = q_full;
  assign accept    = in_valid && !q_full;
  assign is_header = (pos_r == POS_HEADER);
  assign push      = accept && !is_header;

  assign push_entry = '{data:        in_stream_byte,
                        filter:      filter_r,
                        shift_range: range_r,
                        end_flag:    end_r,
                        loop_flag:   loop_r};

  always_comb begin
    pos_nxt    = pos_r;
    filter_nxt = filter_r;
    range_nxt  = range_r;
    end_nxt    = end_r;
    loop_nxt   = loop_r;
    if (accept) begin
      if (is_header) begin
        end_nxt    = in_stream_byte[0];
        loop_nxt   = in_stream_byte[1];
        filter_nxt = in_stream_byte[3:2];
        range_nxt  = in_stream_byte[7:4];
      end
      pos_nxt = (pos_r == POS_LAST) ? POS_HEADER : pos_r + POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= POS_HEADER;
      filter_r <= '0;
      range_r  <= '0;
      end_r    <= 1'b0;
      loop_r   <= 1'b0;
    end else begin
      pos_r    <= pos_nxt;
      filter_r <= filter_nxt;
      range_r  <= range_nxt;
      end_r    <= end_nxt;
      loop_r   <= loop_nxt;
    end
  end

endmodule

>>> src/brr_queue.sv
// ----------------------------------------------------------------------------
// brr_queue
// Short FIFO of pending data bytes between the front and the decode back.
// ----------------------------------------------------------------------------
module brr_queue import brr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  brr_entry_t push_entry,
  input  logic       pop,
  output logic       full,
  output logic       empty,
  output brr_entry_t head
);

  brr_entry_t         mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + Q_CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + Q_PTR_W'(1);
      end
    end
  end

endmodule

>>> src/brr_back.sv
// ----------------------------------------------------------------------------
// brr_back
// Decodes the queue head one nibble per cycle unless stalled: shift, predict,
// saturate, update the two-sample history. Results sit in an output register.
// ----------------------------------------------------------------------------
module brr_back import brr_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  brr_entry_t         q_head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_sample,
  output logic               out_block_is_end,
  output logic               out_block_loops,
  output logic               out_last_of_byte
);

  logic               phase_r;
  logic signed [15:0] prev_r, older_r;
  logic               valid_r;
  logic signed [15:0] sample_r;
  logic               end_r, loop_r, last_r;

  logic               load;
  logic               go;
  logic [3:0]         nib;
  logic signed [19:0] nib_x;
  logic signed [19:0] base;
  logic signed [24:0] pred;
  logic signed [24:0] pred_sh;
  logic signed [25:0] total;
  logic signed [15:0] sat_val;

  // Output register frees up when empty or being taken this cycle
  assign load = !valid_r || !out_stall;
  assign go   = load && !q_empty;
  assign pop  = go && phase_r;

  assign nib     = phase_r ? q_head.data[3:0] : q_head.data[7:4];
  assign nib_x   = 20'(signed'(nib));
  assign base    = nib_x <<< q_head.shift_range;
  assign pred    = 25'(coef_a(q_head.filter)) * 25'(prev_r)
                 + 25'(coef_b(q_head.filter)) * 25'(older_r);
  assign pred_sh = pred >>> 6;
  assign total   = 26'(base) + 26'(pred_sh);

  always_comb begin
    if (total > 26'sd32767) begin
      sat_val = 16'sh7fff;
    end else if (total < -26'sd32768) begin
      sat_val = -16'sh8000;
    end else begin
      sat_val = total[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      sample_r <= sat_val;
      end_r    <= q_head.end_flag;
      loop_r   <= q_head.loop_flag;
      last_r   <= phase_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 1'b0;
      valid_r <= 1'b0;
      prev_r  <= '0;
      older_r <= '0;
    end else begin
      if (load) begin
        valid_r <= !q_empty;
      end
      if (go) begin
        phase_r <= !phase_r;
        older_r <= prev_r;
        prev_r  <= sat_val;
      end
    end
  end

  assign out_valid        = valid_r;
  assign out_sample       = sample_r;
  assign out_block_is_end = end_r;
  assign out_block_loops  = loop_r;
  assign out_last_of_byte = last_r;

endmodule

>>> src/brr_adpcm_block_decoder.sv
// ----------------------------------------------------------------------------
// brr_adpcm_block_decoder
// BRR ADPCM decoder: 9-byte blocks in, two saturated 16-bit samples per
// data byte out, high nibble first.
// ----------------------------------------------------------------------------
//  channel | dir | fields                                      | handshake
//  in_     | in  | stream_byte[7:0]                            | valid / stall
//  out_    | out | sample[15:0], block_is_end, block_loops,    | valid / stall
//          |     | last_of_byte                                |
//
// A data byte yields its two samples, high nibble first, once the decode unit
// is free; the low-nibble sample follows when the high-nibble sample is taken.
// The single predict-and-saturate unit in the back, one sample per cycle while
// the output is not stalled, sets the pace, and the queue accepts new bytes
// while an earlier byte is still in decode. Header bytes produce no beat. A
// byte's first sample passes through the queue and the output register. Reset
// (rst_n low, synchronous) clears block position, header fields, sample history and the queue.
// out_stall holds the output register; the two-entry queue absorbs the gap,
// and in_stall rises only when the queue is full.
// ----------------------------------------------------------------------------
module brr_adpcm_block_decoder import brr_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_stream_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_sample,
  output logic               out_block_is_end,
  output logic               out_block_loops,
  output logic               out_last_of_byte
);

  logic       q_full, q_empty, q_push, q_pop;
  brr_entry_t q_in, q_head;

  brr_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_stream_byte (in_stream_byte),
    .q_full         (q_full),
    .push           (q_push),
    .push_entry     (q_in)
  );

  brr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_in),
    .pop        (q_pop),
    .full       (q_full),
    .empty      (q_empty),
    .head       (q_head)
  );

  brr_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_head           (q_head),
    .pop              (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_sample       (out_sample),
    .out_block_is_end (out_block_is_end),
    .out_block_loops  (out_block_loops),
    .out_last_of_byte (out_last_of_byte)
  );

endmodule

>>> src/brr_checker.sv
// ----------------------------------------------------------------------------
// brr_checker
// Port-level checks for the BRR decoder, bound to the top level.
// ----------------------------------------------------------------------------
module brr_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic [7:0]         in_stream_byte,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [15:0] out_sample,
  input logic               out_block_is_end,
  input logic               out_block_loops,
  input logic               out_last_of_byte
);

  // No beat right after reset
  a_idle_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_valid)
    else $error("out_valid high right after reset");

  // Stalled input beat holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_stream_byte))
    else $error("stalled input beat changed");

  // Stalled beat holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_sample)
                               && $stable(out_last_of_byte))
    else $error("stalled output beat changed");

  // Low-nibble sample follows its high nibble in the very next cycle
  a_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_of_byte |=> out_valid && out_last_of_byte)
    else $error("low-nibble sample did not follow high nibble");

  // Both samples of a byte carry the same header flags
  a_pair_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_of_byte |=>
      $stable(out_block_is_end) && $stable(out_block_loops))
    else $error("header flags differ within a byte");

endmodule

bind brr_adpcm_block_decoder brr_checker u_brr_checker (.*);

>>> bench/tb_brr_adpcm_block_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_brr_adpcm_block_decoder
// Feeds BRR blocks one byte at a time through the valid/stall channel and
// checks every PCM beat against a cycle-free predictor of the decoder: header
// fields, nibble scaling, two-tap prediction with floor shift, saturation.
// ----------------------------------------------------------------------------
module tb_brr_adpcm_block_decoder;
  import brr_pkg::*;

  localparam int CYCLE_LIMIT  = 150000;
  localparam int RANDOM_ITEMS = 750;
  localparam int TAIL_CYCLES  = 8;
  localparam int REPORT_MAX   = 10;

  typedef struct {
    logic signed [15:0] sample;
    logic               is_end;
    logic               loops;
    logic               last;
  } pcm_beat_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         in_stream_byte = 8'h00;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [15:0] out_sample;
  logic               out_block_is_end;
  logic               out_block_loops;
  logic               out_last_of_byte;

  brr_adpcm_block_decoder dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_stream_byte   (in_stream_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_sample       (out_sample),
    .out_block_is_end (out_block_is_end),
    .out_block_loops  (out_block_loops),
    .out_last_of_byte (out_last_of_byte)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Decoder state as the predictor sees it
  int         block_pos;
  logic [1:0] filter_sel;
  logic [3:0] shift_amt;
  logic       end_bit;
  logic       loop_bit;
  int         prev_pcm;
  int         older_pcm;
  int         coef_prev  [4] = '{0, 60, 122, 115};
  int         coef_older [4] = '{0, 0, -60, -52};

  pcm_beat_t  expected_pcm [$];
  int         fail_count;
  int         cycle_count;
  int         stall_pct;
  int         stall_run;

  function automatic logic signed [15:0] decode_nibble(input logic [3:0] nib);
    logic signed [3:0] code;
    int scaled;
    int guess;
    int total;
    code   = nib;
    scaled = int'(code) * (1 << shift_amt);
    guess  = (coef_prev[filter_sel] * prev_pcm + coef_older[filter_sel] * older_pcm) >>> 6;
    total  = scaled + guess;
    if (total > 32767) total = 32767;
    if (total < -32768) total = -32768;
    older_pcm = prev_pcm;
    prev_pcm  = total;
    return total[15:0];
  endfunction

  function automatic void predict_byte(input logic [7:0] b);
    pcm_beat_t beat;
    if (block_pos == 0) begin
      end_bit    = b[0];
      loop_bit   = b[1];
      filter_sel = b[3:2];
      shift_amt  = b[7:4];
      block_pos  = 1;
    end else begin
      beat.is_end = end_bit;
      beat.loops  = loop_bit;
      beat.sample = decode_nibble(b[7:4]);
      beat.last   = 1'b0;
      expected_pcm.push_back(beat);
      beat.sample = decode_nibble(b[3:0]);
      beat.last   = 1'b1;
      expected_pcm.push_back(beat);
      block_pos = (block_pos + 1 >= BLOCK_BYTES) ? 0 : block_pos + 1;
    end
  endfunction

  function automatic void log_failure(input string msg);
    fail_count++;
    if (fail_count <= REPORT_MAX) $display("ERROR: %s", msg);
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("brr_adpcm_block_decoder test failed");
      $finish;
    end
  end

  // Receiver: stall in short runs at a rate the test sets
  always @(negedge clk) begin
    if (stall_run != 0) begin
      out_stall <= 1'b1;
      stall_run <= stall_run - 1;
    end else if ($urandom_range(99) < stall_pct) begin
      out_stall <= 1'b1;
      stall_run <= $urandom_range(3);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : check_beat
    pcm_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_pcm.size() == 0) begin
        log_failure($sformatf("unexpected beat: sample %0d end %b loop %b last %b",
                              out_sample, out_block_is_end, out_block_loops,
                              out_last_of_byte));
      end else begin
        want = expected_pcm.pop_front();
        if (out_sample !== want.sample || out_block_is_end !== want.is_end ||
            out_block_loops !== want.loops || out_last_of_byte !== want.last)
          log_failure($sformatf(
            "beat mismatch: expected sample %0d end %b loop %b last %b, got %0d %b %b %b",
            want.sample, want.is_end, want.loops, want.last,
            out_sample, out_block_is_end, out_block_loops, out_last_of_byte));
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    @(negedge clk);
    in_valid       <= 1'b1;
    in_stream_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_byte(b);
  endtask

  task automatic idle_sender(input int cycles);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  // Hold the input until every predicted beat has drained
  task automatic drain_outputs();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_pcm.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] random_stream_byte();
    logic [3:0] rng;
    int         pick;
    if (block_pos == 0) begin
      rng = ($urandom_range(3) == 0) ? 4'($urandom_range(15, 12))
                                     : 4'($urandom_range(11, 0));
      return {rng, 2'($urandom_range(3)), 1'($urandom_range(1)), 1'($urandom_range(1))};
    end
    pick = $urandom_range(15);
    case (pick)
      0:       return 8'h00;
      1:       return 8'h77;
      2:       return 8'h88;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic send_block(input logic [7:0] header, input logic [7:0] data [], input int n);
    send_byte(header);
    for (int i = 0; i < n; i++) send_byte(data[i]);
  endtask

  // Filter 0 with the end flag and the data byte extremes
  task automatic test_plain_block();
    logic [7:0] data [] = '{8'h00, 8'hFF, 8'h7F, 8'h80, 8'h08, 8'h88, 8'h77, 8'hF7};
    stall_pct = 0;
    send_block(8'h71, data, 8);
  endtask

  // Largest range with filter 3, both flags set, driving into saturation
  task automatic test_saturating_block();
    logic [7:0] data [] = '{8'h77, 8'h77, 8'h88, 8'h88, 8'h70, 8'h07, 8'h00, 8'h00};
    stall_pct = 40;
    send_block(8'hFF, data, 8);
  endtask

  // Filter 2 with the loop flag; leave the block open for the random stream
  task automatic test_open_block();
    logic [7:0] data [] = '{8'h12, 8'h34, 8'h56, 8'hA9, 8'hCE};
    stall_pct = 20;
    send_block(8'hBA, data, 5);
    idle_sender(3);
    send_byte(8'h9D);
  endtask

  task automatic test_random_stream();
    int sent;
    int burst;
    int seg;
    sent = 0;
    for (seg = 0; seg < 4; seg++) begin
      case (seg)
        0: stall_pct = 0;
        1: stall_pct = 30;
        2: begin
          stall_pct = 60;
          drain_outputs();
        end
        default: stall_pct = 50;
      endcase
      while (sent < (seg + 1) * RANDOM_ITEMS / 4) begin
        burst = $urandom_range(20, 1);
        for (int i = 0; i < burst; i++) begin
          send_byte(random_stream_byte());
          sent++;
        end
        if (seg == 1 || seg == 2) idle_sender($urandom_range(5, 1));
      end
    end
  endtask

  initial begin
    block_pos   = 0;
    filter_sel  = '0;
    shift_amt   = '0;
    end_bit     = 1'b0;
    loop_bit    = 1'b0;
    prev_pcm    = 0;
    older_pcm   = 0;
    fail_count  = 0;
    cycle_count = 0;
    stall_pct   = 0;
    stall_run   = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_plain_block();
    test_saturating_block();
    test_open_block();
    test_random_stream();

    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_pcm.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("brr_adpcm_block_decoder test passed");
    end else begin
      $display("brr_adpcm_block_decoder test failed");
    end
    $finish;
  end

endmodule

>>> files.f
src/brr_pkg.sv
src/brr_front.sv
src/brr_queue.sv
src/brr_back.sv
src/brr_adpcm_block_decoder.sv
src/brr_checker.sv
bench/tb_brr_adpcm_block_decoder.sv
